[design/as2p_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// as2p_pkg
// shared types and constants for the pcm16 stereo sample converter
// ----------------------------------------------------------------------------
package as2p_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int POS_W        = 3;
  localparam int FMT_W        = 3;
  localparam int COUNT_W      = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 4;
  localparam int WORD_W       = 32;
  localparam int PCM_W        = 16;
  localparam int MAG_W        = 32;
  localparam int SHIFT_W      = 6;
  localparam int PROD_W       = 47;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  localparam logic [FMT_W-1:0] FMT_INT16   = 3'd0;
  localparam logic [FMT_W-1:0] FMT_INT24   = 3'd1;
  localparam logic [FMT_W-1:0] FMT_INT32   = 3'd2;
  localparam logic [FMT_W-1:0] FMT_FLOAT32 = 3'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

  localparam logic [FMT_W-1:0]   SAMPLE_FORMAT_RESET = FMT_INT16;
  localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RESET = 4'd2;

  localparam logic [SHIFT_W-1:0] SHIFT_INT16 = 6'd15;
  localparam logic [SHIFT_W-1:0] SHIFT_INT24 = 6'd23;
  localparam logic [SHIFT_W-1:0] SHIFT_INT32 = 6'd31;

  localparam logic [7:0] EXP_ALL_ONES   = 8'hFF;
  localparam logic [7:0] EXP_ONE        = 8'd127;
  localparam logic [7:0] FLOAT_SHIFT_BASE = 8'd150;
  localparam logic [7:0] FLOAT_SHIFT_LIMIT = 8'd40;

  localparam logic [14:0] PCM_MAG_MAX = 15'h7FFF;

  typedef enum logic [2:0] {
    KIND_ZERO  = 3'd0,
    KIND_INT16 = 3'd1,
    KIND_INT24 = 3'd2,
    KIND_INT32 = 3'd3,
    KIND_FLOAT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    MODE_LEFT  = 2'd0,
    MODE_RIGHT = 2'd1,
    MODE_MONO  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    kind_t             kind;
    mode_t             mode;
  } cmd_t;

endpackage

[design/audio_sample_to_pcm16_stereo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_sample_to_pcm16_stereo
// converts an interleaved raw sample stream into signed 16-bit stereo pcm
// ----------------------------------------------------------------------------
// input items: one raw sample word (tdata) and a silent flag (tuser) each
// output items: one pcm value (tdata) with its side (tuser, 0 left, 1 right)
// and tlast on the final result of an input item
// sample_format and channel_count are set through the cfg write port; the
// user must write them only while the block is idle, the block does not
// check it; channels 0 and 1 of each frame go out as left and right, further
// channels are dropped, mono input goes out on both sides; accepted items
// pass the queue and the decode and product registers to the output register
// throughput: one item per cycle, set by the output register, while the
// receiver does not stall; a mono item holds that register for two results
// the front classifies and tracks the channel position, a four-entry queue
// lets it keep accepting while the back pipeline is held by a stalled
// receiver; s_tready drops only when the queue is full
// reset: format int16, two channels, position at the first channel, queue
// and pipeline empty
// ----------------------------------------------------------------------------
module audio_sample_to_pcm16_stereo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [as2p_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [as2p_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // sample_word
  input  logic [0:0]                      s_tuser,   // silent
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // pcm_value
  output logic [0:0]                      m_tuser,   // side
  output logic                            m_tlast
);
  import as2p_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  as2p_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  as2p_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  as2p_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_not_empty),
    .q_pop    (q_pop),
    .q_cmd    (head_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[design/as2p_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// as2p_front
// config registers, channel position tracking and item classification
// ----------------------------------------------------------------------------
module as2p_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [as2p_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [as2p_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [as2p_pkg::WORD_W-1:0]   s_tdata,
  input  logic [0:0]                    s_tuser,
  input  logic                          q_full,
  output logic                          q_push,
  output as2p_pkg::cmd_t                q_cmd
);
  import as2p_pkg::*;

  logic [FMT_W-1:0]   sample_format;
  logic [COUNT_W-1:0] channel_count;
  logic [POS_W-1:0]   channel_position;
  logic [POS_W-1:0]   channel_position_next;

  logic [COUNT_W-1:0] count_eff;
  logic [POS_W-1:0]   pos_eff;
  logic [COUNT_W-1:0] pos_inc;
  logic               emit;
  logic               accept;

  always_comb begin
    if (channel_count == '0) begin
      count_eff = COUNT_W'(1);
    end else if (channel_count > COUNT_W'(MAX_CHANNELS)) begin
      count_eff = COUNT_W'(MAX_CHANNELS);
    end else begin
      count_eff = channel_count;
    end
    pos_eff = ({1'b0, channel_position} >= count_eff) ? '0 : channel_position;
    pos_inc = {1'b0, pos_eff} + COUNT_W'(1);
    channel_position_next = (pos_inc >= count_eff) ? '0 : pos_inc[POS_W-1:0];
  end

  always_comb begin
    q_cmd.word = s_tdata;
    if (s_tuser[0]) begin
      q_cmd.kind = KIND_ZERO;
    end else begin
      case (sample_format)
        FMT_INT16:   q_cmd.kind = KIND_INT16;
        FMT_INT24:   q_cmd.kind = KIND_INT24;
        FMT_INT32:   q_cmd.kind = KIND_INT32;
        FMT_FLOAT32: q_cmd.kind = KIND_FLOAT;
        default:     q_cmd.kind = KIND_ZERO;
      endcase
    end
    emit = 1'b1;
    if (count_eff == COUNT_W'(1)) begin
      q_cmd.mode = MODE_MONO;
    end else if (pos_eff == POS_W'(0)) begin
      q_cmd.mode = MODE_LEFT;
    end else if (pos_eff == POS_W'(1)) begin
      q_cmd.mode = MODE_RIGHT;
    end else begin
      q_cmd.mode = MODE_LEFT;
      emit       = 1'b0;
    end
  end

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign q_push   = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format    <= SAMPLE_FORMAT_RESET;
      channel_count    <= CHANNEL_COUNT_RESET;
      channel_position <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_SAMPLE_FORMAT) begin
        sample_format <= cfg_data[FMT_W-1:0];
      end
      if (cfg_we && cfg_index == REG_CHANNEL_COUNT) begin
        channel_count <= cfg_data[COUNT_W-1:0];
      end
      if (accept) begin
        channel_position <= channel_position_next;
      end
    end
  end

endmodule

[design/as2p_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// as2p_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module as2p_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  as2p_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output as2p_pkg::cmd_t head_cmd
);
  import as2p_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("item pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("item popped from empty queue");

  a_count_tracks_push: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + QCNT_W'(1)))
    else $error("queue count out of step with pushes");
`endif

endmodule

[design/as2p_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// as2p_back
// conversion pipeline: magnitude and shift, product by 32767, scale and emit
// ----------------------------------------------------------------------------
module as2p_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  as2p_pkg::cmd_t              q_cmd,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [as2p_pkg::PCM_W-1:0]  m_tdata,
  output logic [0:0]                  m_tuser,
  output logic                        m_tlast
);
  import as2p_pkg::*;

  // decode stage
  logic [32:0]        sval;
  logic [MAG_W-1:0]   d_mag;
  logic [SHIFT_W-1:0] d_shift;
  logic               d_neg;
  logic               d_sat;
  logic               d_zero;
  logic               use_sval;
  logic [7:0]         exp_f;
  logic [22:0]        frac_f;
  logic [7:0]         fshift;

  logic               a_valid;
  logic [MAG_W-1:0]   a_mag;
  logic [SHIFT_W-1:0] a_shift;
  logic               a_neg;
  logic               a_sat;
  logic               a_zero;
  mode_t              a_mode;

  logic               p_valid;
  logic [PROD_W-1:0]  p_prod;
  logic [SHIFT_W-1:0] p_shift;
  logic               p_neg;
  logic               p_sat;
  logic               p_zero;
  mode_t              p_mode;

  logic               out_dup;
  logic [PROD_W-1:0]  scaled;
  logic [14:0]        mag15;
  logic [PCM_W-1:0]   pcm_next;

  logic               out_load_ok;
  logic               p_ready;
  logic               a_ready;

  always_comb begin
    exp_f    = q_cmd.word[30:23];
    frac_f   = q_cmd.word[22:0];
    fshift   = FLOAT_SHIFT_BASE - exp_f;
    sval     = '0;
    use_sval = 1'b0;
    d_mag    = '0;
    d_shift  = '0;
    d_neg    = 1'b0;
    d_sat    = 1'b0;
    d_zero   = 1'b0;
    case (q_cmd.kind)
      KIND_INT16: begin
        sval     = {{17{q_cmd.word[15]}}, q_cmd.word[15:0]};
        use_sval = 1'b1;
        d_shift  = SHIFT_INT16;
      end
      KIND_INT24: begin
        sval     = {{9{q_cmd.word[23]}}, q_cmd.word[23:0]};
        use_sval = 1'b1;
        d_shift  = SHIFT_INT24;
      end
      KIND_INT32: begin
        sval     = {q_cmd.word[31], q_cmd.word};
        use_sval = 1'b1;
        d_shift  = SHIFT_INT32;
      end
      KIND_FLOAT: begin
        d_neg   = q_cmd.word[31];
        d_mag   = {8'd0, 1'b1, frac_f};
        d_shift = fshift[SHIFT_W-1:0];
        if (exp_f == EXP_ALL_ONES) begin
          if (frac_f != '0) begin
            d_zero = 1'b1;
          end else begin
            d_sat = 1'b1;
          end
        end else if (exp_f >= EXP_ONE) begin
          d_sat = 1'b1;
        end else if (exp_f == '0 || fshift >= FLOAT_SHIFT_LIMIT) begin
          d_zero = 1'b1;
        end
      end
      default: begin
        d_zero = 1'b1;
      end
    endcase
    if (use_sval) begin
      d_neg = sval[32];
      d_mag = sval[32] ? 32'(-sval) : sval[31:0];
    end
  end

  assign out_load_ok = !m_tvalid || (m_tready && !out_dup);
  assign p_ready     = !p_valid || out_load_ok;
  assign a_ready     = !a_valid || p_ready;
  assign q_pop       = q_valid && a_ready;

  always_comb begin
    scaled  = p_prod >> p_shift;
    mag15   = (|scaled[31:15]) ? PCM_MAG_MAX : scaled[14:0];
    if (p_zero) begin
      mag15 = '0;
    end else if (p_sat) begin
      mag15 = PCM_MAG_MAX;
    end
    pcm_next = p_neg ? PCM_W'(-{1'b0, mag15}) : {1'b0, mag15};
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_mag   <= d_mag;
      a_shift <= d_shift;
      a_neg   <= d_neg;
      a_sat   <= d_sat;
      a_zero  <= d_zero;
      a_mode  <= q_cmd.mode;
    end
    if (p_ready) begin
      p_prod  <= ({15'd0, a_mag} << 15) - {15'd0, a_mag};
      p_shift <= a_shift;
      p_neg   <= a_neg;
      p_sat   <= a_sat;
      p_zero  <= a_zero;
      p_mode  <= a_mode;
    end
    if (p_valid && out_load_ok) begin
      m_tdata <= pcm_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      p_valid  <= 1'b0;
      m_tvalid <= 1'b0;
      m_tuser  <= '0;
      m_tlast  <= 1'b0;
      out_dup  <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= q_valid;
      end
      if (p_ready) begin
        p_valid <= a_valid;
      end
      if (out_load_ok) begin
        m_tvalid <= p_valid;
        if (p_valid) begin
          m_tuser[0] <= (p_mode == MODE_RIGHT);
          m_tlast    <= (p_mode != MODE_MONO);
          out_dup    <= (p_mode == MODE_MONO);
        end
      end else if (m_tready && out_dup) begin
        // mono: repeat the value on the right side
        m_tuser[0] <= 1'b1;
        m_tlast    <= 1'b1;
        out_dup    <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_dup_only_on_left: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_dup) |-> (!m_tuser[0] && !m_tlast))
    else $error("mono repeat pending on a result other than the left one");

  a_dup_then_right: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_dup && m_tready) |=>
      (m_tvalid && m_tuser[0] && m_tlast && $stable(m_tdata)))
    else $error("mono right result missing after left");
`endif

endmodule

[dv/audio_sample_to_pcm16_stereo_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_sample_to_pcm16_stereo_tb
// self-checking bench for the pcm16 stereo sample converter
// ----------------------------------------------------------------------------
// a clocked driver feeds raw sample items from a backlog queue, a clocked
// monitor checks every pcm result against values worked out by an in-bench
// converter model with its own format, channel count and channel position.
// a short directed run covers the format extremes, float specials, mono,
// dropped channels, clamped counts and a stale position, then randomised
// phases sweep every format and a plan of channel counts with random idling
// on both streams; registers are only rewritten once the block has drained
// ----------------------------------------------------------------------------
module audio_sample_to_pcm16_stereo_tb;
  import as2p_pkg::*;

  localparam logic [FMT_W-1:0] FMT_UNSUPPORTED = 3'd4;
  localparam logic SIDE_LEFT   = 1'b0;
  localparam logic SIDE_RIGHT  = 1'b1;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_PHASES = 24;

  typedef struct {
    logic [31:0] word;
    logic        silent;
  } sample_item_t;

  typedef struct {
    logic [15:0] pcm;
    logic        side;
    logic        last;
  } pcm_result_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata   = '0;
  logic [0:0]            s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [15:0]           m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;

  sample_item_t sample_backlog[$];
  pcm_result_t  pcm_expected[$];

  logic [FMT_W-1:0]   conv_format = SAMPLE_FORMAT_RESET;
  logic [COUNT_W-1:0] conv_count  = CHANNEL_COUNT_RESET;
  logic [POS_W-1:0]   conv_pos    = '0;

  bit idle_on      = 1'b1;
  int src_gap      = 0;
  int sink_gap     = 0;
  int stall_cycles = 0;
  int errors       = 0;

  audio_sample_to_pcm16_stereo dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // sample_word
    .s_tuser  (s_tuser),   // silent
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // pcm_value
    .m_tuser  (m_tuser),   // side
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // magnitude times 32767 shifted down, clamped, sign put back
  function automatic logic [15:0] scaled_pcm(input longint n, input int sh);
    longint mag;
    longint r;
    mag = (n < 0) ? -n : n;
    r = (mag * 32767) >> sh;
    if (r > 32767) r = 32767;
    return 16'((n < 0) ? -r : r);
  endfunction

  function automatic logic [15:0] float_pcm(input logic [31:0] w);
    logic [7:0] e;
    longint     m;
    longint     r;
    int         sh;
    e = w[30:23];
    if (e == EXP_ALL_ONES) begin
      r = (w[22:0] != 0) ? 0 : 32767;
    end else if (e >= EXP_ONE) begin
      r = 32767;
    end else begin
      if (e == 8'd0) begin
        m  = longint'(w[22:0]);
        sh = int'(FLOAT_SHIFT_BASE) - 1;
      end else begin
        m  = longint'({1'b1, w[22:0]});
        sh = int'(FLOAT_SHIFT_BASE) - int'(e);
      end
      r = (sh >= int'(FLOAT_SHIFT_LIMIT)) ? 0 : ((m * 32767) >> sh);
    end
    return 16'(w[31] ? -r : r);
  endfunction

  function automatic logic [15:0] sample_to_pcm(input logic [FMT_W-1:0] fmt,
                                                input logic [31:0] w);
    case (fmt)
      FMT_INT16:   return scaled_pcm(longint'($signed(w[15:0])), int'(SHIFT_INT16));
      FMT_INT24:   return scaled_pcm(longint'($signed(w[23:0])), int'(SHIFT_INT24));
      FMT_INT32:   return scaled_pcm(longint'($signed(w)), int'(SHIFT_INT32));
      FMT_FLOAT32: return float_pcm(w);
      default:     return 16'd0;
    endcase
  endfunction

  function automatic void predict_pcm(input logic [31:0] w, input logic silent);
    int          eff;
    int          p;
    logic [15:0] v;
    eff = int'(conv_count);
    if (eff == 0) eff = 1;
    if (eff > MAX_CHANNELS) eff = MAX_CHANNELS;
    p = int'(conv_pos);
    if (p >= eff) p = 0;
    v = silent ? 16'd0 : sample_to_pcm(conv_format, w);
    if (eff == 1) begin
      pcm_expected.push_back('{v, SIDE_LEFT, 1'b0});
      pcm_expected.push_back('{v, SIDE_RIGHT, 1'b1});
    end else if (p == 0) begin
      pcm_expected.push_back('{v, SIDE_LEFT, 1'b1});
    end else if (p == 1) begin
      pcm_expected.push_back('{v, SIDE_RIGHT, 1'b1});
    end
    p++;
    if (p >= eff) p = 0;
    conv_pos = POS_W'(p);
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0:       w = 32'h0000_7FFF;
          1:       w = 32'hFFFF_8000;
          2:       w = 32'h007F_FFFF;
          3:       w = 32'h0080_0000;
          4:       w = 32'h7FFF_FFFF;
          default: w = 32'h8000_0000;
        endcase
      end
      1, 2: w = {w[31], 8'($urandom_range(100, 135)), w[22:0]};
      3: begin
        w = {w[31], ($urandom_range(0, 1) ? 8'hFF : 8'h00), w[22:0]};
        if ($urandom_range(0, 3) == 0) w[22:0] = '0;
      end
      4: begin
        w = 32'($urandom_range(0, 300));
        if ($urandom_range(0, 1)) w = -w;
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) predict_pcm(s_tdata, s_tuser[0]);
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= sample_backlog[0].word;
          s_tuser  <= sample_backlog[0].silent;
          void'(sample_backlog.pop_front());
          if (idle_on && $urandom_range(0, 11) == 0) src_gap = $urandom_range(1, 15);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pcm_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pcm_expected.size() == 0) begin
          report_mismatch("unexpected result, pcm", int'($signed(m_tdata)), 0);
        end else begin
          want = pcm_expected.pop_front();
          if (m_tdata !== want.pcm)
            report_mismatch("pcm", int'($signed(m_tdata)), int'($signed(want.pcm)));
          if (m_tuser[0] !== want.side) report_mismatch("side", m_tuser[0], want.side);
          if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 15);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || s_tvalid || pcm_expected.size() != 0);
    // dropped channels leave no result to wait on
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SAMPLE_FORMAT) conv_format = val[FMT_W-1:0];
    else conv_count = val;
  endtask

  task automatic set_mode(input logic [FMT_W-1:0] fmt, input logic [COUNT_W-1:0] cnt);
    wait_drained();
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(fmt));
    write_reg(REG_CHANNEL_COUNT, cnt);
    @(negedge clk);
  endtask

  initial begin
    logic [COUNT_W-1:0] count_plan[16];
    logic [FMT_W-1:0]   fmt;
    logic [COUNT_W-1:0] cnt;
    int                 n;
    count_plan = '{4'd2, 4'd1, 4'd0, 4'd8, 4'd15, 4'd3, 4'd9, 4'd5,
                   4'd1, 4'd2, 4'd7, 4'd0, 4'd4, 4'd6, 4'd8, 4'd15};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: int16 extremes, upper bits ignored, silent
    sample_backlog.push_back('{32'h0000_7FFF, 1'b0});
    sample_backlog.push_back('{32'h0000_8000, 1'b0});
    sample_backlog.push_back('{32'hFFFF_0000, 1'b0});
    sample_backlog.push_back('{32'h0000_FFFF, 1'b0});
    sample_backlog.push_back('{32'h1234_8001, 1'b1});

    // int24 mono
    set_mode(FMT_INT24, 4'd1);
    sample_backlog.push_back('{32'h007F_FFFF, 1'b0});
    sample_backlog.push_back('{32'hFF80_0000, 1'b0});

    // int32 with a zero count
    set_mode(FMT_INT32, 4'd0);
    sample_backlog.push_back('{32'h8000_0000, 1'b0});

    // float specials
    set_mode(FMT_FLOAT32, 4'd2);
    sample_backlog.push_back('{32'h3F80_0000, 1'b0});
    sample_backlog.push_back('{32'hBF80_0000, 1'b0});
    sample_backlog.push_back('{32'h7F80_0000, 1'b0});
    sample_backlog.push_back('{32'hFF80_0000, 1'b0});
    sample_backlog.push_back('{32'h7FC0_0000, 1'b0});
    sample_backlog.push_back('{32'h8000_0000, 1'b0});
    sample_backlog.push_back('{32'h0000_0001, 1'b0});
    sample_backlog.push_back('{32'h3F7F_FFFF, 1'b0});
    sample_backlog.push_back('{32'hBEFF_FFFF, 1'b0});
    sample_backlog.push_back('{32'h3F80_0000, 1'b1});

    // unsupported format, oversized count, third channel dropped
    set_mode(FMT_UNSUPPORTED, 4'd15);
    sample_backlog.push_back('{32'h7FFF_FFFF, 1'b0});
    sample_backlog.push_back('{32'h8000_0000, 1'b0});
    sample_backlog.push_back('{32'h0000_7FFF, 1'b0});

    // position left at three, count cut to two
    set_mode(3'd7, 4'd2);
    sample_backlog.push_back('{32'h0000_7FFF, 1'b0});
    sample_backlog.push_back('{32'hFFFF_FFFF, 1'b0});

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      fmt = (p < 8) ? FMT_W'(p) : FMT_W'($urandom_range(0, 4));
      cnt = (p < 16) ? count_plan[p] : COUNT_W'($urandom_range(0, 15));
      if (p == RANDOM_PHASES - 1) begin
        fmt = FMT_FLOAT32;
        cnt = 4'd2;
      end
      set_mode(fmt, cnt);
      if (p == RANDOM_PHASES - 1) idle_on = 1'b0;
      n = $urandom_range(40, 80);
      for (int i = 0; i < n; i++)
        sample_backlog.push_back('{random_word(), ($urandom_range(0, 7) == 0)});
    end

    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
